// ===== rtl/core/lpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

	localparam int PAGE_W  = 16;
	localparam int CFG_W   = 4;
	localparam int COUNT_W = 16;
	localparam int INDEX_W = 3;

	localparam logic [COUNT_W-1:0] FAULT_MAX = {COUNT_W{1'b1}};

	typedef struct packed {
		logic [PAGE_W-1:0] page_number;
		logic              restart;
	} lpr_req_t;

	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] frame_index;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
		logic [COUNT_W-1:0] fault_count;
	} lpr_res_t;

	// outcome of the frame search for one request
	typedef struct packed {
		logic hit;
		logic evict;
	} lpr_sel_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpr_frame_sel.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpr_frame_sel import lpr_pkg::*; #(
	parameter int FRAMES = 8,
	parameter int IDX_W  = 3,
	parameter int RANK_W = 3
) (
	input  wire logic [PAGE_W-1:0]              page,
	input  wire logic [FRAMES-1:0]              frame_valid,
	input  wire logic [FRAMES-1:0][RANK_W-1:0]  frame_rank,
	input  wire logic [FRAMES-1:0][PAGE_W-1:0]  frame_page,
	input  wire logic [FRAMES-1:0]              active,
	output lpr_sel_t                            sel,
	output logic      [IDX_W-1:0]               slot
);

	logic [FRAMES-1:0] hit_vec;
	logic [FRAMES-1:0] empty_vec;
	logic [FRAMES-1:0] victim_vec;

	// lowest set bit of a vector
	function automatic logic [IDX_W-1:0] first_set(input logic [FRAMES-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

	always_comb begin
		for (int f = 0; f < FRAMES; f++) begin
			hit_vec[f]   = active[f] && frame_valid[f] && (frame_page[f] == page);
			empty_vec[f] = active[f] && !frame_valid[f];
		end
	end

	// oldest active frame; ties go to the lower frame
	always_comb begin
		for (int f = 0; f < FRAMES; f++) begin
			victim_vec[f] = active[f];
			for (int g = 0; g < FRAMES; g++) begin
				if (active[g] && (g < f) && !(frame_rank[f] > frame_rank[g])) begin
					victim_vec[f] = 1'b0;
				end
				if (active[g] && (g > f) && (frame_rank[f] < frame_rank[g])) begin
					victim_vec[f] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		sel.hit   = |hit_vec;
		sel.evict = !(|hit_vec) && !(|empty_vec);
		if (|hit_vec) begin
			slot = first_set(hit_vec);
		end else if (|empty_vec) begin
			slot = first_set(empty_vec);
		end else begin
			slot = first_set(victim_vec);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lru_page_replacement.sv =====
`timescale 1ns / 1ps
`default_nettype none

// LRU page replacement over FRAMES page frames. Each request carries a page
// number; the result reports hit or fault, the frame that holds the page
// afterwards, any page that was replaced and the saturating fault count.
// A request is registered, then searched against all active frames in
// parallel while the frame table and recency ranks update in the same cycle,
// so one request is taken every clock unless res_stall holds back a pending
// result. The tag compare plus rank compare matrix sets the cycle time.
// cfg_wdata sets how many frames take part (0 acts as 1, values above FRAMES
// act as FRAMES); write it only while no request is in flight. A request with
// restart set empties all frames and zeroes the count before it is handled.

module lru_page_replacement import lpr_pkg::*; #(
	parameter int FRAMES = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire lpr_req_t          req_data,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output lpr_res_t               res_data,
	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_wdata
);

	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = 6;
	localparam int CFG_MAX = (1 << CFG_W) - 1;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'((FRAMES > CFG_MAX) ? CFG_MAX : FRAMES);

	logic [CFG_W-1:0]               cfg_q;
	logic                           s1_valid_q;
	lpr_req_t                       req_s1;
	logic [FRAMES-1:0]              valid_q;
	logic [FRAMES-1:0][RANK_W-1:0]  rank_q;
	logic [FRAMES-1:0][PAGE_W-1:0]  page_q;
	logic [COUNT_W-1:0]             fault_q;
	logic                           res_valid_q;
	lpr_res_t                       res_q;

	logic [CNT_W-1:0]               count;
	logic [FRAMES-1:0]              active;
	logic [FRAMES-1:0]              eff_valid;
	logic [FRAMES-1:0][RANK_W-1:0]  eff_rank;
	logic [COUNT_W-1:0]             eff_fault;
	logic [COUNT_W-1:0]             fault_next;
	lpr_sel_t                       sel;
	logic [IDX_W-1:0]               slot;
	logic                           was_valid;
	logic [RANK_W-1:0]              old_age;
	logic [FRAMES-1:0][RANK_W-1:0]  rank_next;
	logic [FRAMES-1:0]              valid_next;
	logic                           advance;

	always_comb begin
		count = CNT_W'(cfg_q);
		if (count == '0) begin
			count = CNT_W'(1);
		end
		if (count > CNT_W'(FRAMES)) begin
			count = CNT_W'(FRAMES);
		end
		for (int f = 0; f < FRAMES; f++) begin
			active[f] = CNT_W'(f) < count;
		end
	end

	// apply restart before the search
	always_comb begin
		eff_valid = req_s1.restart ? '0 : valid_q;
		eff_rank  = req_s1.restart ? '0 : rank_q;
		eff_fault = req_s1.restart ? '0 : fault_q;
	end

	lpr_frame_sel #(
		.FRAMES (FRAMES),
		.IDX_W  (IDX_W),
		.RANK_W (RANK_W)
	) u_sel (
		.page        (req_s1.page_number),
		.frame_valid (eff_valid),
		.frame_rank  (eff_rank),
		.frame_page  (page_q),
		.active      (active),
		.sel         (sel),
		.slot        (slot)
	);

	always_comb begin
		was_valid = eff_valid[slot];
		old_age   = eff_rank[slot];
		// age every valid frame younger than the touched one
		for (int f = 0; f < FRAMES; f++) begin
			rank_next[f] = eff_rank[f];
			if (eff_valid[f] && (!was_valid || (eff_rank[f] < old_age))) begin
				rank_next[f] = eff_rank[f] + RANK_W'(1);
			end
		end
		rank_next[slot] = '0;

		valid_next       = eff_valid;
		valid_next[slot] = 1'b1;

		if (sel.hit || (eff_fault == FAULT_MAX)) begin
			fault_next = eff_fault;
		end else begin
			fault_next = eff_fault + COUNT_W'(1);
		end
	end

	assign advance   = s1_valid_q && (!res_valid_q || !res_stall);
	assign req_stall = s1_valid_q && !advance;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= CFG_RESET;
			s1_valid_q  <= 1'b0;
			valid_q     <= '0;
			rank_q      <= '0;
			fault_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (!req_stall) begin
				s1_valid_q <= req_valid;
			end
			if (advance) begin
				valid_q     <= valid_next;
				rank_q      <= rank_next;
				fault_q     <= fault_next;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
		if (advance) begin
			if (!sel.hit) begin
				page_q[slot] <= req_s1.page_number;
			end
			res_q.hit           <= sel.hit;
			res_q.frame_index   <= INDEX_W'(slot);
			res_q.evicted_valid <= sel.evict;
			res_q.evicted_page  <= sel.evict ? page_q[slot] : '0;
			res_q.fault_count   <= fault_next;
		end
	end

endmodule

`default_nettype wire

// ===== verif/lpr_checker.sv =====
`timescale 1ns / 1ps

module lpr_checker import lpr_pkg::*; #(
	parameter int FRAMES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  lpr_req_t          req_data,
	input  logic              res_valid,
	input  logic              res_stall,
	input  lpr_res_t          res_data,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	output int                pending,
	output int                fail_count
);

	logic [PAGE_W-1:0]  held_page [FRAMES];
	logic               occupied  [FRAMES];
	logic [INDEX_W-1:0] age_rank  [FRAMES];
	logic [COUNT_W-1:0] faults_seen;
	logic [CFG_W-1:0]   frames_sel;
	lpr_res_t           outcome_q [$];

	task automatic clear_frames();
		for (int f = 0; f < FRAMES; f++) begin
			occupied[f] = 1'b0;
			age_rank[f] = '0;
		end
		faults_seen = '0;
	endtask

	// Look the page up, fill or replace a frame, and age the others.
	task automatic replace_page(input lpr_req_t r, output lpr_res_t o);
		int n, slot;
		bit found, empty;
		bit was_held;
		logic [INDEX_W-1:0] oldest, age;
		o = '0;
		if (r.restart)
			clear_frames();
		n = frames_sel;
		if (n < 1) n = 1;
		if (n > FRAMES) n = FRAMES;
		found = 1'b0;
		slot = 0;
		for (int f = 0; f < n; f++) begin
			if (!found && occupied[f] && held_page[f] == r.page_number) begin
				found = 1'b1;
				slot = f;
			end
		end
		if (found) begin
			o.hit = 1'b1;
		end else begin
			empty = 1'b0;
			for (int f = 0; f < n; f++) begin
				if (!empty && !occupied[f]) begin
					empty = 1'b1;
					slot = f;
				end
			end
			if (!empty) begin
				oldest = '0;
				slot = 0;
				for (int f = 0; f < n; f++) begin
					if (age_rank[f] > oldest) begin
						oldest = age_rank[f];
						slot = f;
					end
				end
				o.evicted_valid = 1'b1;
				o.evicted_page = held_page[slot];
			end
			held_page[slot] = r.page_number;
			if (faults_seen != FAULT_MAX)
				faults_seen = faults_seen + COUNT_W'(1);
		end
		// age only the frames that were more recent than the one touched
		was_held = occupied[slot];
		age = age_rank[slot];
		for (int f = 0; f < FRAMES; f++) begin
			if (f != slot && occupied[f] && (!was_held || age_rank[f] < age))
				age_rank[f] = age_rank[f] + INDEX_W'(1);
		end
		age_rank[slot] = '0;
		occupied[slot] = 1'b1;
		o.frame_index = INDEX_W'(slot);
		o.fault_count = faults_seen;
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lpr_res_t want, next;
		if (!arst_n) begin
			for (int f = 0; f < FRAMES; f++)
				held_page[f] = '0;
			clear_frames();
			frames_sel = CFG_W'(FRAMES);
			outcome_q.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (outcome_q.size() == 0) begin
					$display("%0t ns: result with nothing outstanding, expected none, actual %h",
						$time, res_data);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					check_field("hit", 32'(want.hit), 32'(res_data.hit));
					check_field("frame_index", 32'(want.frame_index),
						32'(res_data.frame_index));
					check_field("evicted_valid", 32'(want.evicted_valid),
						32'(res_data.evicted_valid));
					check_field("evicted_page", 32'(want.evicted_page),
						32'(res_data.evicted_page));
					check_field("fault_count", 32'(want.fault_count),
						32'(res_data.fault_count));
				end
			end
			if (req_valid && !req_stall) begin
				replace_page(req_data, next);
				outcome_q.push_back(next);
			end
			if (cfg_we)
				frames_sel = cfg_wdata;
			pending = outcome_q.size();
		end
	end

endmodule

// ===== verif/lru_page_replacement_tb.sv =====
`timescale 1ns / 1ps

module lru_page_replacement_tb import lpr_pkg::*;;

	localparam int FRAMES         = 8;
	localparam int RESET_CYCLES   = 12;
	localparam int LONG_HOLD      = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MIX_PHASES     = 12;
	localparam int FRESH_ITEMS    = 20;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	lpr_req_t         req_data = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	lpr_res_t         res_data;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	int pending;
	int fail_count;
	int burst_left = 0;
	int idle_max = 0;
	bit hold_req = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lru_page_replacement #(.FRAMES(FRAMES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	lpr_checker #(.FRAMES(FRAMES)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so the caller must not let time pass before the
	// next request or drain_refs.
	task automatic send_ref(input logic [PAGE_W-1:0] page, input logic restart);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, idle_max);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_valid <= 1'b1;
		req_data <= '{page_number: page, restart: restart};
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic drain_refs();
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Reference a small pool of pages so that hits and evictions both happen,
	// with some stray pages and restarts mixed in.
	task automatic mixed_phase(input logic [CFG_W-1:0] sel, input int n_items,
			input bit hold);
		logic [PAGE_W-1:0] pool [$];
		int active, depth, roll;
		logic [PAGE_W-1:0] page;
		drain_refs();
		write_frames(sel);
		// ask for the long receiver hold only once requests are flowing
		hold_req = hold;
		active = (sel == 0) ? 1 : ((sel > FRAMES) ? FRAMES : sel);
		depth = active + $urandom_range(0, 3);
		if ($urandom_range(0, 4) == 0)
			depth = (active > 1) ? active - 1 : 1;
		for (int i = 0; i < depth; i++) begin
			roll = $urandom_range(0, 15);
			if (roll == 0)
				pool.push_back('0);
			else if (roll == 1)
				pool.push_back('1);
			else
				pool.push_back(PAGE_W'($urandom));
		end
		for (int i = 0; i < n_items; i++) begin
			roll = $urandom_range(0, 99);
			page = pool[$urandom_range(0, depth - 1)];
			if (roll < 7)
				send_ref(PAGE_W'($urandom), 1'b0);
			else if (roll < 10)
				send_ref(page, 1'b1);
			else
				send_ref(page, 1'b0);
		end
	endtask

	// Receiver: alternate stretches of free flow, random stalls and a periodic
	// stall pattern; hold off once for a long stretch when asked.
	initial begin : res_side
		int stretch, style, pct;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			stretch = $urandom_range(16, 96);
			style = $urandom_range(0, 2);
			pct = $urandom_range(10, 80);
			for (int k = 0; k < stretch; k++) begin
				@(negedge clk);
				if (hold_req && !held) begin
					held = 1'b1;
					res_stall <= 1'b1;
					repeat (LONG_HOLD) @(negedge clk);
				end
				case (style)
					0: begin
						res_stall <= 1'b0;
					end
					1: begin
						res_stall <= ($urandom_range(0, 99) < pct);
					end
					default: begin
						res_stall <= ((k % 4) == 3);
					end
				endcase
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		logic [CFG_W-1:0] sel;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Fill all eight frames, hit, then replace the least recent twice.
		idle_max = 2;
		send_ref(16'h0000, 1'b0);
		send_ref(16'hFFFF, 1'b0);
		send_ref(16'h0000, 1'b0);
		send_ref(16'h8000, 1'b0);
		send_ref(16'h0001, 1'b0);
		send_ref(16'h5555, 1'b0);
		send_ref(16'hAAAA, 1'b0);
		send_ref(16'h1234, 1'b0);
		send_ref(16'h4321, 1'b0);
		send_ref(16'h7777, 1'b0);
		send_ref(16'hFFFF, 1'b0);
		send_ref(16'h0000, 1'b1);

		// Two frames: thrash across three pages.
		drain_refs();
		write_frames(4'd2);
		send_ref(16'h0A0A, 1'b0);
		send_ref(16'h0B0B, 1'b0);
		send_ref(16'h0C0C, 1'b0);
		send_ref(16'h0A0A, 1'b0);

		// Zero acts as one frame; the page left in frame one stays put.
		drain_refs();
		write_frames(4'd0);
		send_ref(16'h00FF, 1'b0);
		send_ref(16'hFF00, 1'b0);
		send_ref(16'h0C0C, 1'b0);

		// Grow past the frame count: the same page now sits in two frames.
		drain_refs();
		write_frames(4'd15);
		send_ref(16'h0C0C, 1'b0);
		send_ref(16'hFFFF, 1'b0);
		send_ref(16'h0C0C, 1'b0);

		for (int p = 0; p < MIX_PHASES; p++) begin
			case (p)
				0: sel = 4'd1;
				1: sel = 4'd8;
				2: sel = 4'd15;
				3: sel = 4'd0;
				default: sel = CFG_W'($urandom_range(0, 15));
			endcase
			// phase three keeps the sender busy while the receiver holds off
			if (p == 3) begin
				idle_max = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: idle_max = 0;
					1: idle_max = 3;
					2: idle_max = 12;
					default: idle_max = 30;
				endcase
			end
			mixed_phase(sel, $urandom_range(95, 125), p == 3);
		end

		// One frame and a fresh page every time: each fresh page faults and
		// evicts, then restart the count.
		drain_refs();
		write_frames(4'd1);
		idle_max = 0;
		send_ref(16'h0000, 1'b1);
		for (int i = 1; i <= FRESH_ITEMS; i++)
			send_ref(PAGE_W'(i), 1'b0);
		send_ref(16'h0001, 1'b1);

		drain_refs();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
